[hw/rtl/vad_pkg.sv]
// vad_pkg: shared types and constants for the vector angle pipeline
// holds the arctangent table, angle constants and the sideband word type
// no dependencies
package vad_pkg;

    // angle accumulator: degrees with 20 fractional bits, signed
    localparam int ZFRAC = 20;
    localparam int ZW = 29;
    // unsigned width of a mapped angle in [0, 360] degrees
    localparam int RW = 29;
    localparam int TABLE_LEN = 24;

    // atan(2^-i) in degrees, scaled by 2^20 and rounded
    localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
        29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121,
        29'sd3750058,  29'sd1876857,  29'sd938658,   29'sd469357,
        29'sd234682,   29'sd117342,   29'sd58671,    29'sd29335,
        29'sd14668,    29'sd7334,     29'sd3667,     29'sd1833,
        29'sd917,      29'sd458,      29'sd229,      29'sd115,
        29'sd57,       29'sd29,       29'sd14,       29'sd7
    };

    localparam logic signed [ZW-1:0] Z_LIMIT = 29'sd94371840;
    localparam logic [RW-1:0] R_180 = 29'd188743680;
    localparam logic [RW-1:0] R_360 = 29'd377487360;

    // inputs that lie on an axis bypass the cordic result
    typedef enum logic [2:0] {
        AXIS_NONE = 3'd0,
        AXIS_ZERO = 3'd1,
        AXIS_90   = 3'd2,
        AXIS_180  = 3'd3,
        AXIS_270  = 3'd4
    } axis_t;

    typedef enum logic [1:0] {
        QUAD_1 = 2'd0,
        QUAD_2 = 2'd1,
        QUAD_3 = 2'd2,
        QUAD_4 = 2'd3
    } quad_t;

    // travels alongside each word through the pipeline
    typedef struct packed {
        logic  vld;
        axis_t axis;
        quad_t quad;
    } side_t;

endpackage

[hw/rtl/vector_angle_degrees.sv]
// vector_angle_degrees: angle of a signed (x, y) vector in 1/2^ANGLE_FRAC_BITS degree
// fully unrolled cordic vectoring pipeline, one register per iteration
// depends on vad_pkg
//
// A coordinate pair is taken at every clock edge where start is high (busy is
// always low, so a new word can follow every cycle). The input stage is loaded
// at the edge that takes the word; after it come one stage per cordic
// iteration, a quadrant mapping stage and the rounding output register; the
// angle appears on angle_deg with done high for one cycle once the word has
// passed through them all. Throughput is one word per cycle; results come
// out in input order and cannot be held off.
// Axis inputs give exact 0, 90, 180 or 270 degrees, (0,0) gives 0, and an
// angle that rounds up to 360 degrees is returned as 0.
module vector_angle_degrees #(
    parameter int COORD_BITS      = 16,
    parameter int STAGES          = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_BITS-1:0]      x_coord,
    input  logic signed [COORD_BITS-1:0]      y_coord,
    output logic                              done,
    output logic        [ANGLE_FRAC_BITS+8:0] angle_deg
);
    import vad_pkg::*;

    // working width: magnitude shifted by STAGES, cordic gain and guard bits
    localparam int W  = COORD_BITS + STAGES + 3;
    localparam int OW = ANGLE_FRAC_BITS + 9;
    localparam int SH = ZFRAC - ANGLE_FRAC_BITS;
    localparam logic [RW:0]   HALF   = (RW + 1)'(1) << (SH - 1);
    localparam logic [RW:0]   FULL   = (RW + 1)'(360) << ANGLE_FRAC_BITS;
    localparam logic [OW-1:0] DEG90  = OW'(90) << ANGLE_FRAC_BITS;
    localparam logic [OW-1:0] DEG180 = OW'(180) << ANGLE_FRAC_BITS;
    localparam logic [OW-1:0] DEG270 = OW'(270) << ANGLE_FRAC_BITS;

    logic signed [W-1:0]  x_reg    [STAGES+1];
    logic signed [W-1:0]  y_reg    [STAGES+1];
    logic signed [ZW-1:0] z_reg    [STAGES+1];
    side_t                side_reg [STAGES+1];
    logic signed [W-1:0]  x_next   [STAGES+1];
    logic signed [W-1:0]  y_next   [STAGES+1];
    logic signed [ZW-1:0] z_next   [STAGES+1];
    side_t                side_next[STAGES+1];

    side_t           map_side_reg, map_side_next;
    logic [RW-1:0]   map_ang_reg, map_ang_next;
    logic            done_reg, done_next;
    logic [OW-1:0]   angle_reg, angle_next;

    logic [COORD_BITS:0] x_ext, y_ext, x_abs, y_abs;
    logic                x_zero, y_zero;
    logic signed [ZW-1:0] z_fin;
    logic [RW-1:0]       z_clip;
    logic [RW:0]         rnd_sum, rnd_val;

    assign busy = 1'b0;

    // input stage: fold into the first quadrant, flag axis cases
    always_comb
    begin
        x_ext  = {x_coord[COORD_BITS-1], x_coord};
        y_ext  = {y_coord[COORD_BITS-1], y_coord};
        x_abs  = x_ext[COORD_BITS] ? (~x_ext + 1'b1) : x_ext;
        y_abs  = y_ext[COORD_BITS] ? (~y_ext + 1'b1) : y_ext;
        x_zero = (x_coord == '0);
        y_zero = (y_coord == '0);

        x_next[0] = {2'b00, x_abs, {STAGES{1'b0}}};
        y_next[0] = {2'b00, y_abs, {STAGES{1'b0}}};
        z_next[0] = '0;

        side_next[0].vld = start && !busy;
        if (x_zero)
        begin
            if (y_zero)
                side_next[0].axis = AXIS_ZERO;
            else if (y_coord[COORD_BITS-1])
                side_next[0].axis = AXIS_270;
            else
                side_next[0].axis = AXIS_90;
        end
        else if (y_zero)
            side_next[0].axis = x_coord[COORD_BITS-1] ? AXIS_180 : AXIS_ZERO;
        else
            side_next[0].axis = AXIS_NONE;

        case ({x_coord[COORD_BITS-1], y_coord[COORD_BITS-1]})
            2'b00:   side_next[0].quad = QUAD_1;
            2'b10:   side_next[0].quad = QUAD_2;
            2'b11:   side_next[0].quad = QUAD_3;
            default: side_next[0].quad = QUAD_4;
        endcase

        // one cordic rotation per stage, shift amount fixed by the stage index
        for (int i = 0; i < STAGES; i++)
        begin
            side_next[i+1] = side_reg[i];
            if (!y_reg[i][W-1])
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + ATAN_TAB[i];
            end
            else
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - ATAN_TAB[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STAGES; i++)
                side_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i <= STAGES; i++)
                side_reg[i] <= side_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= STAGES; i++)
        begin
            x_reg[i] <= x_next[i];
            y_reg[i] <= y_next[i];
            z_reg[i] <= z_next[i];
        end
    end

    // clamp to [0, 90] and place the angle in its quadrant
    always_comb
    begin
        z_fin = z_reg[STAGES];
        if (z_fin[ZW-1])
            z_clip = '0;
        else if (z_fin > Z_LIMIT)
            z_clip = RW'(Z_LIMIT);
        else
            z_clip = RW'(z_fin);

        map_side_next = side_reg[STAGES];
        case (side_reg[STAGES].quad)
            QUAD_1:  map_ang_next = z_clip;
            QUAD_2:  map_ang_next = R_180 - z_clip;
            QUAD_3:  map_ang_next = R_180 + z_clip;
            QUAD_4:  map_ang_next = R_360 - z_clip;
            default: map_ang_next = z_clip;
        endcase
    end

    // round to the output unit, wrap 360 to 0, or give the exact axis angle
    always_comb
    begin
        rnd_sum   = {1'b0, map_ang_reg} + HALF;
        rnd_val   = rnd_sum >> SH;
        done_next = map_side_reg.vld;
        case (map_side_reg.axis)
            AXIS_NONE: angle_next = (rnd_val >= FULL) ? '0 : OW'(rnd_val);
            AXIS_ZERO: angle_next = '0;
            AXIS_90:   angle_next = DEG90;
            AXIS_180:  angle_next = DEG180;
            AXIS_270:  angle_next = DEG270;
            default:   angle_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_side_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            map_side_reg <= map_side_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        map_ang_reg <= map_ang_next;
        angle_reg   <= angle_next;
    end

    assign done      = done_reg;
    assign angle_deg = angle_reg;

`ifndef SYNTHESIS
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((RW + 1)'(angle_deg) < FULL))
        else $error("angle word out of range");

    a_map_range: assert property (@(posedge clk) disable iff (!rst_n)
        (map_side_reg.vld && (map_side_reg.axis == AXIS_NONE)) |-> (map_ang_reg <= R_360))
        else $error("mapped angle beyond full turn");

    a_axis_90: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (x_coord == '0) && !y_coord[COORD_BITS-1] && (y_coord != '0))
        |-> ##(STAGES + 3) (done && (angle_deg == DEG90)))
        else $error("positive y axis word did not give 90 degrees");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        side_reg[STAGES].vld |-> ##2 done)
        else $error("word lost between cordic and output");
`endif

endmodule
